[rtl/integer_to_text_formatter_assert.svh]
// Assertion macros shared by the integer-to-text formatter RTL.
// Every use expects clk_i and rst_ni in the including module's scope.
`ifndef INTEGER_TO_TEXT_FORMATTER_ASSERT_SVH
`define INTEGER_TO_TEXT_FORMATTER_ASSERT_SVH

// Checks a property on every rising edge while out of reset.
`define ITF_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("integer_to_text_formatter: assertion failed");

// Checks that a condition never holds while out of reset.
`define ITF_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("integer_to_text_formatter: forbidden condition seen");

`endif

[rtl/itf_pkg.sv]
// Types and constants for the integer-to-text formatter.
// No dependencies; imported by integer_to_text_formatter.
package itf_pkg;

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CONV = 5'b00010,
    ST_SKIP = 5'b00100,
    ST_PRE  = 5'b01000,
    ST_DIG  = 5'b10000
  } state_e;

  // Width of one output digit in the shift register.
  typedef enum logic [1:0] {
    DW_1 = 2'd0,
    DW_3 = 2'd1,
    DW_4 = 2'd2
  } digit_width_e;

  // Radix codes of the input transaction.
  localparam logic [1:0] RADIX_DEC = 2'd0;
  localparam logic [1:0] RADIX_OCT = 2'd1;
  localparam logic [1:0] RADIX_BIN = 2'd2;
  localparam logic [1:0] RADIX_HEX = 2'd3;

  localparam logic [6:0] CH_ZERO    = 7'h30;
  localparam logic [6:0] CH_UPPER_A = 7'h41;
  localparam logic [6:0] CH_LOWER_A = 7'h61;
  localparam logic [6:0] CH_MINUS   = 7'h2D;
  localparam logic [6:0] CH_PLUS    = 7'h2B;
  localparam logic [6:0] CH_SPACE   = 7'h20;
  localparam logic [6:0] CH_UPPER_X = 7'h58;
  localparam logic [6:0] CH_LOWER_X = 7'h78;

endpackage

[rtl/integer_to_text_formatter.sv]
// Integer-to-text formatter: one integer in, its ASCII characters out.
// Depends on itf_pkg and integer_to_text_formatter_assert.svh.
//
// Takes one integer with its formatting flags and emits the text one
// character per output transaction, the last one flagged by last_char_o.
// Work is digit serial. Decimal values (and all signed values) first pass
// through a shift-and-add-3 binary-to-BCD loop over all VALUE_BITS bits;
// other radices skip it. Leading zero digits are then dropped at one per
// cycle, and after that one character is emitted per cycle when the output
// is not stalled. A 32-bit value has 12 decimal, 12 hex, 16 octal and 48
// binary digit slots, and without output stalls binary is the slowest
// radix. A new number is taken once the last character of the previous
// one is in the output register.
module integer_to_text_formatter
  import itf_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] value_i,
  input  logic        signed_mode_i,
  input  logic [1:0]  radix_code_i,
  input  logic        upper_case_i,
  input  logic        plus_flag_i,
  input  logic        space_flag_i,
  input  logic        prefix_flag_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [6:0]  text_char_o,
  output logic        last_char_o
);

  `include "integer_to_text_formatter_assert.svh"

  // Decimal digits needed for VALUE_BITS bits (1233/4096 ~ log10 of 2).
  localparam int ND   = ((VALUE_BITS * 1233) >> 12) + 1;
  // Digit register width, a multiple of 1, 3 and 4 bits.
  localparam int WP   = 12 * ((ND + 2) / 3);
  localparam int NBCD = WP / 4;
  localparam int RW   = $clog2(WP + 1);
  localparam int BW   = $clog2(VALUE_BITS + 1);

  state_e                state_q, state_d;
  logic [WP-1:0]         work_q, work_d;
  logic [VALUE_BITS-1:0] bin_q, bin_d;
  logic [BW-1:0]         bitcnt_q, bitcnt_d;
  logic [RW-1:0]         rem_q, rem_d;
  digit_width_e          dw_q, dw_d;
  logic                  caps_q, caps_d;
  logic [6:0]            pre_q [4];
  logic [2:0]            pre_cnt_q, pre_cnt_d;

  logic                  in_accept;
  logic                  can_emit;
  logic                  emit;
  logic [6:0]            emit_char;
  logic                  emit_last;

  logic                  out_valid_q;
  logic [6:0]            char_q;
  logic                  last_q;

  logic [VALUE_BITS-1:0] v;
  logic [VALUE_BITS-1:0] mag;
  logic                  neg;
  logic [6:0]            pre_new [4];
  logic [2:0]            pre_new_cnt;
  logic [WP-1:0]         bcd_adj;
  logic [3:0]            top_digit;
  logic [WP-1:0]         work_shl;
  logic [6:0]            digit_char;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign can_emit   = !out_valid_q || !out_stall_i;

  // Magnitude and sign of the incoming value.
  assign v   = VALUE_BITS'(value_i);
  assign neg = signed_mode_i && v[VALUE_BITS-1];
  assign mag = neg ? (~v + VALUE_BITS'(1)) : v;

  // Sign and prefix characters, in emission order.
  always_comb begin
    pre_new_cnt = 3'd0;
    for (int k = 0; k < 4; k++) begin
      pre_new[k] = CH_SPACE;
    end
    if (signed_mode_i) begin
      if (neg) begin
        pre_new[pre_new_cnt[1:0]] = CH_MINUS;
        pre_new_cnt = pre_new_cnt + 3'd1;
      end else if (space_flag_i) begin
        pre_new[pre_new_cnt[1:0]] = CH_SPACE;
        pre_new_cnt = pre_new_cnt + 3'd1;
      end else if (plus_flag_i) begin
        pre_new[pre_new_cnt[1:0]] = CH_PLUS;
        pre_new_cnt = pre_new_cnt + 3'd1;
      end
    end else begin
      if (plus_flag_i) begin
        pre_new[pre_new_cnt[1:0]] = CH_PLUS;
        pre_new_cnt = pre_new_cnt + 3'd1;
      end
      if (space_flag_i) begin
        pre_new[pre_new_cnt[1:0]] = CH_SPACE;
        pre_new_cnt = pre_new_cnt + 3'd1;
      end
      if (prefix_flag_i && (radix_code_i inside {RADIX_OCT, RADIX_HEX})) begin
        pre_new[pre_new_cnt[1:0]] = CH_ZERO;
        pre_new_cnt = pre_new_cnt + 3'd1;
      end
      if (prefix_flag_i && radix_code_i == RADIX_HEX) begin
        pre_new[pre_new_cnt[1:0]] = upper_case_i ? CH_UPPER_X : CH_LOWER_X;
        pre_new_cnt = pre_new_cnt + 3'd1;
      end
    end
  end

  // Add 3 to every BCD digit of five or more before the next shift.
  always_comb begin
    for (int i = 0; i < NBCD; i++) begin
      if (work_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = work_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = work_q[4*i +: 4];
      end
    end
  end

  // Most significant digit and the register shifted past it.
  always_comb begin
    case (dw_q)
      DW_1: begin
        top_digit = {3'b000, work_q[WP-1]};
        work_shl  = {work_q[WP-2:0], 1'b0};
      end
      DW_3: begin
        top_digit = {1'b0, work_q[WP-1 -: 3]};
        work_shl  = {work_q[WP-4:0], 3'b000};
      end
      DW_4: begin
        top_digit = work_q[WP-1 -: 4];
        work_shl  = {work_q[WP-5:0], 4'b0000};
      end
      default: begin
        top_digit = 4'd0;
        work_shl  = work_q;
      end
    endcase
  end

  assign digit_char = (top_digit < 4'd10) ? (CH_ZERO + {3'b000, top_digit})
                    : ((caps_q ? CH_UPPER_A : CH_LOWER_A) + {3'b000, top_digit} - 7'd10);

  always_comb begin
    state_d   = state_q;
    work_d    = work_q;
    bin_d     = bin_q;
    bitcnt_d  = bitcnt_q;
    rem_d     = rem_q;
    dw_d      = dw_q;
    caps_d    = caps_q;
    pre_cnt_d = pre_cnt_q;
    emit      = 1'b0;
    emit_char = CH_SPACE;
    emit_last = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          pre_cnt_d = pre_new_cnt;
          caps_d    = upper_case_i && !signed_mode_i;
          bin_d     = mag;
          bitcnt_d  = BW'(VALUE_BITS);
          if (signed_mode_i || radix_code_i == RADIX_DEC) begin
            dw_d    = DW_4;
            work_d  = '0;
            state_d = ST_CONV;
          end else begin
            case (radix_code_i)
              RADIX_OCT: dw_d = DW_3;
              RADIX_BIN: dw_d = DW_1;
              default:   dw_d = DW_4;
            endcase
            work_d  = WP'(mag);
            state_d = ST_SKIP;
          end
          case (dw_d)
            DW_1:    rem_d = RW'(WP);
            DW_3:    rem_d = RW'(WP / 3);
            default: rem_d = RW'(WP / 4);
          endcase
        end
      end
      ST_CONV: begin
        work_d   = {bcd_adj[WP-2:0], bin_q[VALUE_BITS-1]};
        bin_d    = {bin_q[VALUE_BITS-2:0], 1'b0};
        bitcnt_d = bitcnt_q - BW'(1);
        if (bitcnt_q == BW'(1)) begin
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (top_digit == 4'd0 && rem_q > RW'(1)) begin
          work_d = work_shl;
          rem_d  = rem_q - RW'(1);
        end else if (pre_cnt_q != 3'd0) begin
          state_d = ST_PRE;
        end else begin
          state_d = ST_DIG;
        end
      end
      ST_PRE: begin
        emit_char = pre_q[0];
        if (can_emit) begin
          emit      = 1'b1;
          pre_cnt_d = pre_cnt_q - 3'd1;
          if (pre_cnt_q == 3'd1) begin
            state_d = ST_DIG;
          end
        end
      end
      ST_DIG: begin
        emit_char = digit_char;
        emit_last = (rem_q == RW'(1));
        if (can_emit) begin
          emit   = 1'b1;
          work_d = work_shl;
          rem_d  = rem_q - RW'(1);
          if (rem_q == RW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pre_cnt_q   <= 3'd0;
      bitcnt_q    <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pre_cnt_q <= pre_cnt_d;
      bitcnt_q  <= bitcnt_d;
      rem_q     <= rem_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    bin_q  <= bin_d;
    dw_q   <= dw_d;
    caps_q <= caps_d;
    if (in_accept) begin
      for (int k = 0; k < 4; k++) begin
        pre_q[k] <= pre_new[k];
      end
    end else if (state_q == ST_PRE && can_emit) begin
      pre_q[0] <= pre_q[1];
      pre_q[1] <= pre_q[2];
      pre_q[2] <= pre_q[3];
      pre_q[3] <= CH_SPACE;
    end
    if (emit) begin
      char_q <= emit_char;
      last_q <= emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign text_char_o = char_q;
  assign last_char_o = last_q;

  `ITF_ASSERT(a_rem_nonzero, (state_q == ST_SKIP || state_q == ST_DIG) |-> rem_q != '0)
  `ITF_ASSERT(a_conv_count, (state_q == ST_CONV) |-> bitcnt_q != '0)
  `ITF_ASSERT_NEVER(a_pre_count_range, pre_cnt_q > 3'd4)
  `ITF_ASSERT(a_last_ends_item, (emit && emit_last) |=> (state_q == ST_IDLE && last_q))
  `ITF_ASSERT(a_pre_has_chars, (state_q == ST_PRE) |-> pre_cnt_q != 3'd0)

endmodule

[sim/text_stream_checker.sv]
// Checker for the integer-to-text formatter: it predicts each character from the accepted input.
// It compares every accepted output character against that prediction in order.
// Depends on itf_pkg for the radix codes and the character constants.
`timescale 1ns / 100ps

module text_stream_checker
  import itf_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [31:0] value_i,
  input  logic        signed_mode_i,
  input  logic [1:0]  radix_code_i,
  input  logic        upper_case_i,
  input  logic        plus_flag_i,
  input  logic        space_flag_i,
  input  logic        prefix_flag_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [6:0]  text_char_i,
  input  logic        last_char_i,
  output int          error_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } text_char_t;

  text_char_t expected_text[$];
  int         mismatches = 0;

  // Appends the characters that one number should produce.
  task automatic format_into_text(input logic [31:0] value, input logic sgn,
                                  input logic [1:0] radix, input logic caps,
                                  input logic plus, input logic space,
                                  input logic prefix);
    logic [63:0] mask;
    logic [63:0] mag;
    logic [63:0] base;
    logic [63:0] digit;
    logic [6:0]  line[$];
    logic [6:0]  digits[$];
    logic        letter_caps;
    mask = (VALUE_BITS >= 64) ? '1 : ((64'd1 << VALUE_BITS) - 64'd1);
    mag  = {32'd0, value} & mask;
    letter_caps = caps;
    if (sgn) begin
      base = 64'd10;
      letter_caps = 1'b0;
      if (mag[VALUE_BITS-1]) begin
        // The most negative value keeps its magnitude as an unsigned number.
        mag = (~mag + 64'd1) & mask;
        line.push_back(CH_MINUS);
      end else if (space) begin
        line.push_back(CH_SPACE);
      end else if (plus) begin
        line.push_back(CH_PLUS);
      end
    end else begin
      case (radix)
        RADIX_DEC: base = 64'd10;
        RADIX_OCT: base = 64'd8;
        RADIX_BIN: base = 64'd2;
        default:   base = 64'd16;
      endcase
      if (plus) line.push_back(CH_PLUS);
      if (space) line.push_back(CH_SPACE);
      if (prefix && radix == RADIX_OCT) line.push_back(CH_ZERO);
      if (prefix && radix == RADIX_HEX) begin
        line.push_back(CH_ZERO);
        line.push_back(caps ? CH_UPPER_X : CH_LOWER_X);
      end
    end
    if (mag == 64'd0) digits.push_back(CH_ZERO);
    while (mag != 64'd0) begin
      digit = mag % base;
      if (digit < 64'd10) begin
        digits.push_front(CH_ZERO + 7'(digit));
      end else begin
        digits.push_front((letter_caps ? CH_UPPER_A : CH_LOWER_A) + 7'(digit - 64'd10));
      end
      mag = mag / base;
    end
    foreach (digits[i]) line.push_back(digits[i]);
    foreach (line[i]) expected_text.push_back('{ch: line[i], last: (i == line.size() - 1)});
  endtask

  always @(posedge clk_i) begin
    text_char_t want;
    if (rst_ni) begin
      // Outputs are checked first; a character can never belong to a number
      // taken at the same edge.
      if (out_valid_i && !out_stall_i) begin
        if (expected_text.size() == 0) begin
          $error("text_char: no character expected, got %h", text_char_i);
          mismatches++;
        end else begin
          want = expected_text.pop_front();
          if (text_char_i !== want.ch) begin
            $error("text_char: expected %h, got %h", want.ch, text_char_i);
            mismatches++;
          end
          if (last_char_i !== want.last) begin
            $error("last_char: expected %b, got %b", want.last, last_char_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        format_into_text(value_i, signed_mode_i, radix_code_i, upper_case_i,
                         plus_flag_i, space_flag_i, prefix_flag_i);
      end
    end
    pending_o     <= expected_text.size();
    error_count_o <= mismatches;
  end

endmodule

[sim/testbench.sv]
// Top of the integer-to-text formatter testbench: clock, reset, number stimulus, output stalls.
// It instantiates the block and text_stream_checker and gives the verdict.
// Depends on itf_pkg and the formatter RTL.
`timescale 1ns / 100ps

module testbench;
  import itf_pkg::*;

  localparam int VALUE_BITS     = 32;
  localparam int RANDOM_NUMBERS = 270;
  localparam int DRAIN_CYCLES   = 100;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_BEAT
  } stall_mode_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_stall_o;
  logic [31:0] value_i       = '0;
  logic        signed_mode_i = 1'b0;
  logic [1:0]  radix_code_i  = RADIX_DEC;
  logic        upper_case_i  = 1'b0;
  logic        plus_flag_i   = 1'b0;
  logic        space_flag_i  = 1'b0;
  logic        prefix_flag_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i   = 1'b0;
  logic [6:0]  text_char_o;
  logic        last_char_o;

  int          error_count;
  int          chars_pending;
  int          burst_left    = 0;
  bit          steady_sender = 1'b0;
  stall_mode_e stall_mode    = STALL_NONE;
  int          stall_phase   = 0;

  integer_to_text_formatter #(
    .VALUE_BITS(VALUE_BITS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .value_i      (value_i),
    .signed_mode_i(signed_mode_i),
    .radix_code_i (radix_code_i),
    .upper_case_i (upper_case_i),
    .plus_flag_i  (plus_flag_i),
    .space_flag_i (space_flag_i),
    .prefix_flag_i(prefix_flag_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .text_char_o  (text_char_o),
    .last_char_o  (last_char_o)
  );

  text_stream_checker #(
    .VALUE_BITS(VALUE_BITS)
  ) u_text_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .value_i      (value_i),
    .signed_mode_i(signed_mode_i),
    .radix_code_i (radix_code_i),
    .upper_case_i (upper_case_i),
    .plus_flag_i  (plus_flag_i),
    .space_flag_i (space_flag_i),
    .prefix_flag_i(prefix_flag_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .text_char_i  (text_char_o),
    .last_char_i  (last_char_o),
    .error_count_o(error_count),
    .pending_o    (chars_pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // The receiver switches at random between stall patterns.
  always @(posedge clk_i) begin
    if (stall_phase == 0) begin
      stall_mode  <= stall_mode_e'($urandom_range(0, 3));
      stall_phase <= $urandom_range(20, 200);
    end else begin
      stall_phase <= stall_phase - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall_i <= 1'b0;
      STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
      default:     out_stall_i <= stall_phase[2];
    endcase
  end

  // Sends one number as a transaction, with a random gap at the start of each burst unless steady_sender is set.
  task automatic send_number(input logic [31:0] value, input logic sgn,
                             input logic [1:0] radix, input logic caps,
                             input logic plus, input logic space,
                             input logic prefix);
    int gap;
    if (burst_left == 0) begin
      gap = steady_sender ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    value_i       <= value;
    signed_mode_i <= sgn;
    radix_code_i  <= radix;
    upper_case_i  <= caps;
    plus_flag_i   <= plus;
    space_flag_i  <= space;
    prefix_flag_i <= prefix;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  initial begin
    logic [31:0] value;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed numbers: extremes, every radix, sign and prefix rules.
    send_number(32'd0, 1'b0, RADIX_DEC, 1'b0, 1'b0, 1'b0, 1'b0);
    send_number('1, 1'b0, RADIX_DEC, 1'b0, 1'b0, 1'b0, 1'b0);
    send_number('1, 1'b0, RADIX_OCT, 1'b0, 1'b0, 1'b0, 1'b1);
    send_number('1, 1'b0, RADIX_BIN, 1'b0, 1'b1, 1'b1, 1'b1);
    send_number(32'hDEAD_BEEF, 1'b0, RADIX_HEX, 1'b0, 1'b0, 1'b0, 1'b1);
    send_number(32'hCAFE_F00D, 1'b0, RADIX_HEX, 1'b1, 1'b0, 1'b0, 1'b1);
    send_number(32'hABCD_EF12, 1'b0, RADIX_HEX, 1'b1, 1'b0, 1'b0, 1'b0);
    send_number(32'd0, 1'b0, RADIX_OCT, 1'b0, 1'b0, 1'b0, 1'b1);
    send_number(32'd0, 1'b0, RADIX_HEX, 1'b1, 1'b1, 1'b1, 1'b1);
    send_number(32'd12345, 1'b0, RADIX_DEC, 1'b0, 1'b0, 1'b0, 1'b1);
    send_number(32'd5, 1'b0, RADIX_BIN, 1'b0, 1'b1, 1'b0, 1'b1);
    send_number(32'd1, 1'b0, RADIX_DEC, 1'b0, 1'b1, 1'b1, 1'b0);
    send_number(32'h8000_0000, 1'b1, RADIX_DEC, 1'b0, 1'b0, 1'b0, 1'b0);
    send_number('1, 1'b1, RADIX_DEC, 1'b0, 1'b0, 1'b0, 1'b0);
    send_number(32'h7FFF_FFFF, 1'b1, RADIX_DEC, 1'b0, 1'b1, 1'b0, 1'b0);
    send_number(32'd42, 1'b1, RADIX_DEC, 1'b0, 1'b1, 1'b1, 1'b0);
    send_number(32'd0, 1'b1, RADIX_DEC, 1'b0, 1'b0, 1'b1, 1'b0);
    send_number(32'd0, 1'b1, RADIX_DEC, 1'b0, 1'b0, 1'b0, 1'b0);
    send_number(32'hFFFF_FF85, 1'b1, RADIX_HEX, 1'b1, 1'b1, 1'b1, 1'b1);
    send_number(32'd77, 1'b1, RADIX_OCT, 1'b1, 1'b0, 1'b0, 1'b1);

    for (int k = 0; k < RANDOM_NUMBERS; k++) begin
      // Every third stretch of numbers runs back to back.
      steady_sender = ((k / 45) % 3 == 1);
      case ($urandom_range(0, 7))
        0: begin
          case ($urandom_range(0, 3))
            0:       value = 32'h8000_0000;
            1:       value = '1;
            2:       value = 32'h7FFF_FFFF;
            default: value = 32'h8000_0001;
          endcase
        end
        1:       value = $urandom_range(0, 20);
        default: value = $urandom >> $urandom_range(0, 31);
      endcase
      send_number(value, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
    in_valid_i <= 1'b0;

    do @(posedge clk_i); while (chars_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout: the formatter stopped making progress");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
